### rtl/gehc_pkg.sv
package gehc_pkg;

   // Identification bytes and header constants.
   localparam logic [7:0]  MAGIC0       = 8'h7F;
   localparam logic [7:0]  MAGIC1       = 8'h45;
   localparam logic [7:0]  MAGIC2       = 8'h4C;
   localparam logic [7:0]  MAGIC3       = 8'h46;
   localparam logic [7:0]  CLASS_64     = 8'd2;
   localparam logic [15:0] MACHINE_GPU  = 16'd190;
   localparam logic [7:0]  ARCH_MASK    = 8'hFF;
   localparam logic [31:0] HEADER_BYTES = 32'd64;

   // Byte positions inside the 64-byte header.
   localparam logic [5:0] POS_MAGIC0 = 6'd0;
   localparam logic [5:0] POS_MAGIC1 = 6'd1;
   localparam logic [5:0] POS_MAGIC2 = 6'd2;
   localparam logic [5:0] POS_MAGIC3 = 6'd3;
   localparam logic [5:0] POS_CLASS  = 6'd4;
   localparam logic [5:0] POS_FLAGS  = 6'd48;
   localparam logic [5:0] POS_LAST   = 6'd63;

   // Eight-byte groups, selected by position bits 5..3.
   localparam logic [2:0] GROUP_PRG_OFF = 3'd4;
   localparam logic [2:0] GROUP_SEC_OFF = 3'd5;

   // Two-byte fields, selected by position bits 5..1.
   localparam logic [4:0] PAIR_MACHINE   = 5'd9;
   localparam logic [4:0] PAIR_PRG_ESIZE = 5'd27;
   localparam logic [4:0] PAIR_PRG_COUNT = 5'd28;
   localparam logic [4:0] PAIR_SEC_ESIZE = 5'd29;
   localparam logic [4:0] PAIR_SEC_COUNT = 5'd30;

   typedef struct packed {
      logic        ok;
      logic [7:0]  flags_low;
      logic [63:0] prg_off;
      logic [63:0] sec_off;
      logic [15:0] prg_esize;
      logic [15:0] prg_count;
      logic [15:0] sec_esize;
      logic [15:0] sec_count;
      logic [31:0] limit;
   } header_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/gehc_req_if.sv
interface gehc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic [31:0] available_length;

   modport source(output valid, output data_byte, output first_byte,
                  output available_length, input ready);
   modport sink(input valid, input data_byte, input first_byte,
                input available_length, output ready);
endinterface

### rtl/gehc_rsp_if.sv
interface gehc_rsp_if;
   logic        valid;
   logic        ready;
   logic        header_valid;
   logic [7:0]  arch_number;
   logic [31:0] image_size;

   modport source(output valid, output header_valid, output arch_number,
                  output image_size, input ready);
   modport sink(input valid, input header_valid, input arch_number,
                input image_size, output ready);
endinterface

### rtl/gehc_front.sv
module gehc_front (
   input  logic                      clock,
   input  logic                      reset,
   gehc_req_if.sink                  req_chan,
   input  gehc_pkg::queue_status_type q_status,
   output logic                      push,
   output gehc_pkg::header_rec_type  rec_out
);
   import gehc_pkg::*;

   logic [5:0]  pos_ff, pos_in, pos;
   logic        ident_ff, ident_in, ident_cur, ident_next, ident_bad;
   logic [31:0] limit_ff, limit_in, limit_cur;
   logic [15:0] machine_ff, machine_in;
   logic [7:0]  flags_ff, flags_in;
   logic [63:0] prg_off_ff, prg_off_in;
   logic [63:0] sec_off_ff, sec_off_in;
   logic [15:0] prg_esize_ff, prg_esize_in;
   logic [15:0] prg_count_ff, prg_count_in;
   logic [15:0] sec_esize_ff, sec_esize_in;
   logic [15:0] sec_count_ff, sec_count_in;
   logic        accept, last;
   logic [7:0]  b;

   // Only the final byte of a header needs queue space, but holding off on a
   // full queue keeps ready independent of the payload.
   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;

   always_comb begin
      pos       = req_chan.first_byte ? 6'd0 : pos_ff;
      ident_cur = req_chan.first_byte ? 1'b1 : ident_ff;
      limit_cur = req_chan.first_byte ? req_chan.available_length : limit_ff;
      last      = (pos == POS_LAST);

      unique case (pos)
         POS_MAGIC0: ident_bad = (b != MAGIC0);
         POS_MAGIC1: ident_bad = (b != MAGIC1);
         POS_MAGIC2: ident_bad = (b != MAGIC2);
         POS_MAGIC3: ident_bad = (b != MAGIC3);
         POS_CLASS:  ident_bad = (b != CLASS_64);
         default:    ident_bad = 1'b0;
      endcase
      ident_next = ident_cur && !ident_bad;

      machine_in   = machine_ff;
      flags_in     = flags_ff;
      prg_off_in   = prg_off_ff;
      sec_off_in   = sec_off_ff;
      prg_esize_in = prg_esize_ff;
      prg_count_in = prg_count_ff;
      sec_esize_in = sec_esize_ff;
      sec_count_in = sec_count_ff;
      if (accept) begin
         if (pos[5:1] == PAIR_MACHINE)   machine_in[{pos[0], 3'b000} +: 8]   = b;
         if (pos[5:1] == PAIR_PRG_ESIZE) prg_esize_in[{pos[0], 3'b000} +: 8] = b;
         if (pos[5:1] == PAIR_PRG_COUNT) prg_count_in[{pos[0], 3'b000} +: 8] = b;
         if (pos[5:1] == PAIR_SEC_ESIZE) sec_esize_in[{pos[0], 3'b000} +: 8] = b;
         if (pos[5:1] == PAIR_SEC_COUNT) sec_count_in[{pos[0], 3'b000} +: 8] = b;
         if (pos[5:3] == GROUP_PRG_OFF)  prg_off_in[{pos[2:0], 3'b000} +: 8] = b;
         if (pos[5:3] == GROUP_SEC_OFF)  sec_off_in[{pos[2:0], 3'b000} +: 8] = b;
         if (pos == POS_FLAGS)           flags_in = b & ARCH_MASK;
      end

      if (accept) begin
         pos_in   = last ? 6'd0 : pos + 6'd1;
         ident_in = last ? 1'b1 : ident_next;
         limit_in = limit_cur;
      end else begin
         pos_in   = pos_ff;
         ident_in = ident_ff;
         limit_in = limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 6'd0;
         ident_ff <= 1'b1;
         limit_ff <= 32'd0;
      end else begin
         pos_ff   <= pos_in;
         ident_ff <= ident_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      machine_ff   <= machine_in;
      flags_ff     <= flags_in;
      prg_off_ff   <= prg_off_in;
      sec_off_ff   <= sec_off_in;
      prg_esize_ff <= prg_esize_in;
      prg_count_ff <= prg_count_in;
      sec_esize_ff <= sec_esize_in;
      sec_count_ff <= sec_count_in;
   end

   // Nothing is captured at the final position, so the stored fields are
   // complete when the last byte transfers.
   assign push = accept && last;

   always_comb begin
      rec_out.ok        = ident_next && (machine_ff == MACHINE_GPU) &&
                          (limit_cur >= HEADER_BYTES);
      rec_out.flags_low = flags_ff;
      rec_out.prg_off   = prg_off_ff;
      rec_out.sec_off   = sec_off_ff;
      rec_out.prg_esize = prg_esize_ff;
      rec_out.prg_count = prg_count_ff;
      rec_out.sec_esize = sec_esize_ff;
      rec_out.sec_count = sec_count_ff;
      rec_out.limit     = limit_cur;
   end

endmodule

### rtl/gehc_queue.sv
module gehc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gehc_pkg::header_rec_type   wr_data,
   input  logic                       pop,
   output gehc_pkg::header_rec_type   rd_data,
   output gehc_pkg::queue_status_type status
);
   import gehc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   header_rec_type   mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= wr_data;
   end

endmodule

### rtl/gehc_back.sv
module gehc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  gehc_pkg::header_rec_type rec_in,
   input  logic                     rec_valid,
   output logic                     pop,
   gehc_rsp_if.source               rsp_chan
);
   import gehc_pkg::*;

   // A table fits when its offset is within the limit and its length fits in
   // the room that remains after the offset.
   function automatic logic table_fits(logic [63:0] off, logic [31:0] len,
                                       logic [31:0] limit);
      logic [31:0] room;
      room = limit - off[31:0];
      return (off[63:32] == 32'd0) && (off[31:0] <= limit) && (len <= room);
   endfunction

   logic        out_ready, s2_ready, s1_ready;

   logic        s1_v_ff, s1_v_in;
   logic        s1_ok_ff;
   logic [7:0]  s1_flags_ff;
   logic [63:0] s1_prg_off_ff, s1_sec_off_ff;
   logic [31:0] s1_limit_ff, s1_prg_len_ff, s1_sec_len_ff;

   logic        s2_v_ff, s2_v_in;
   logic        s2_ok_ff, s2_fit_ff;
   logic [7:0]  s2_flags_ff;
   logic [31:0] s2_prg_end_ff, s2_sec_end_ff;

   logic        out_v_ff, out_v_in;
   logic        out_valid_ff;
   logic [7:0]  out_arch_ff;
   logic [31:0] out_size_ff;
   logic [31:0] end_max, size_in;

   assign out_ready = !out_v_ff || rsp_chan.ready;
   assign s2_ready  = !s2_v_ff || out_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign pop       = rec_valid && s1_ready;

   assign s1_v_in  = s1_ready ? rec_valid : s1_v_ff;
   assign s2_v_in  = s2_ready ? s1_v_ff : s2_v_ff;
   assign out_v_in = out_ready ? s2_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Stage one: table lengths, one 16 by 16 product per table.
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ok_ff      <= rec_in.ok;
         s1_flags_ff   <= rec_in.flags_low;
         s1_prg_off_ff <= rec_in.prg_off;
         s1_sec_off_ff <= rec_in.sec_off;
         s1_limit_ff   <= rec_in.limit;
         s1_prg_len_ff <= 32'(rec_in.prg_esize) * 32'(rec_in.prg_count);
         s1_sec_len_ff <= 32'(rec_in.sec_esize) * 32'(rec_in.sec_count);
      end
   end

   // Stage two: fit checks and table ends. An end that fits stays below 2^32.
   always_ff @(posedge clock) begin
      if (s2_ready && s1_v_ff) begin
         s2_ok_ff      <= s1_ok_ff;
         s2_flags_ff   <= s1_flags_ff;
         s2_fit_ff     <= table_fits(s1_prg_off_ff, s1_prg_len_ff, s1_limit_ff) &&
                          table_fits(s1_sec_off_ff, s1_sec_len_ff, s1_limit_ff);
         s2_prg_end_ff <= s1_prg_off_ff[31:0] + s1_prg_len_ff;
         s2_sec_end_ff <= s1_sec_off_ff[31:0] + s1_sec_len_ff;
      end
   end

   // Output register: the later table end, kept only past the header itself.
   always_comb begin
      end_max = (s2_sec_end_ff > s2_prg_end_ff) ? s2_sec_end_ff : s2_prg_end_ff;
      size_in = (s2_ok_ff && s2_fit_ff && (end_max > HEADER_BYTES)) ? end_max : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_v_ff) begin
         out_valid_ff <= s2_ok_ff;
         out_arch_ff  <= s2_ok_ff ? s2_flags_ff : 8'd0;
         out_size_ff  <= size_in;
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.header_valid = out_valid_ff;
   assign rsp_chan.arch_number  = out_arch_ff;
   assign rsp_chan.image_size   = out_size_ff;

endmodule

### rtl/gpu_elf_header_checker.sv
// 64-bit ELF header checker for GPU code images.
// req_chan carries the header one byte per transfer in file order. first_byte
// marks byte 0 and samples available_length; without it, position counting
// simply continues and wraps after byte 63 to start the next header.
// After the transfer of byte 63, one result goes out on rsp_chan: header_valid,
// arch_number (low flags byte, 0 if invalid) and image_size (later table end,
// 0 when a table does not fit, the header is invalid or the end is at most 64).
// Throughput is one byte per cycle while the queue is not full. The front
// captures fields and hands a finished header to a small queue; the back
// computes the table lengths, the fit checks and the size in three registered
// stages. A result passes from the queue through stage one, stage two and the
// output register before it is valid on rsp_chan.
// When rsp_chan stalls, the back stages and then the queue fill up, and
// req_chan.ready drops only while the queue is full.
// Reset clears the byte position, the latched length (so a header seen before
// any first_byte is invalid), the queue and all stage valid flags.
module gpu_elf_header_checker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   gehc_req_if.sink   req_chan,
   gehc_rsp_if.source rsp_chan
);
   import gehc_pkg::*;

   header_rec_type   front_rec, queue_rec;
   queue_status_type q_status;
   logic             push, pop;

   gehc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .rec_out  (front_rec)
   );

   gehc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_rec),
      .pop     (pop),
      .rd_data (queue_rec),
      .status  (q_status)
   );

   gehc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_in    (queue_rec),
      .rec_valid (!q_status.empty),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("header pushed into a full queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_status.empty)
      else $error("pushed header missing from queue");

   a_size_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.image_size != 32'd0) |-> rsp_chan.header_valid)
      else $error("nonzero image size on an invalid header");

   a_arch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.header_valid |-> rsp_chan.arch_number == 8'd0)
      else $error("architecture byte on an invalid header");

endmodule

### dv/testbench.sv
module testbench;
   import gehc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_BYTES = 256;

   typedef struct {
      bit          header_valid;
      logic [7:0]  arch_number;
      logic [31:0] image_size;
   } header_result_type;

   logic clock;
   logic reset;

   gehc_req_if req_chan();
   gehc_rsp_if rsp_chan();

   gpu_elf_header_checker uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow of the header capture state.
   logic [5:0]  byte_pos;
   bit          ident_good;
   logic [15:0] machine;
   logic [7:0]  flags_byte;
   logic [63:0] prg_offset;
   logic [63:0] sec_offset;
   logic [15:0] prg_esize;
   logic [15:0] prg_count;
   logic [15:0] sec_esize;
   logic [15:0] sec_count;
   logic [31:0] length_limit;

   header_result_type results_due[$];
   logic [7:0]        hdr[64];

   int  error_count = 0;
   int  bytes_sent = 0;
   int  headers_checked = 0;
   int  valid_seen = 0;
   int  sized_seen = 0;
   int  cycle_count = 0;
   int  rsp_hold_left;
   bit  req_idle_on;
   bit  rsp_stall_on;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  results_due.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit table_fits(input logic [63:0] off, input logic [15:0] esize,
                                     input logic [15:0] count, input logic [31:0] lim,
                                     output logic [63:0] table_end);
      logic [63:0] len;
      len = 64'(esize) * 64'(count);
      table_end = off + len;
      return !(off > 64'(lim) || len > 64'(lim) - off);
   endfunction

   function automatic void capture_header_byte(input logic [7:0] b, input bit fb,
                                               input logic [31:0] len);
      logic [5:0]        p;
      logic [63:0]       sec_end;
      logic [63:0]       prg_end;
      logic [63:0]       size;
      bit                ok;
      bit                sec_ok;
      bit                prg_ok;
      header_result_type r;
      if (fb) begin
         byte_pos = '0;
         ident_good = 1'b1;
         length_limit = len;
      end
      p = byte_pos;
      case (p)
         POS_MAGIC0: if (b != MAGIC0) ident_good = 1'b0;
         POS_MAGIC1: if (b != MAGIC1) ident_good = 1'b0;
         POS_MAGIC2: if (b != MAGIC2) ident_good = 1'b0;
         POS_MAGIC3: if (b != MAGIC3) ident_good = 1'b0;
         POS_CLASS:  if (b != CLASS_64) ident_good = 1'b0;
         POS_FLAGS:  flags_byte = b & ARCH_MASK;
         default: ;
      endcase
      // Multi-byte fields are little-endian.
      if (p == 18 || p == 19) machine[8*(p-18) +: 8] = b;
      if (p >= 32 && p <= 39) prg_offset[8*(p-32) +: 8] = b;
      if (p >= 40 && p <= 47) sec_offset[8*(p-40) +: 8] = b;
      if (p == 54 || p == 55) prg_esize[8*(p-54) +: 8] = b;
      if (p == 56 || p == 57) prg_count[8*(p-56) +: 8] = b;
      if (p == 58 || p == 59) sec_esize[8*(p-58) +: 8] = b;
      if (p == 60 || p == 61) sec_count[8*(p-60) +: 8] = b;
      if (p != POS_LAST) begin
         byte_pos = p + 6'd1;
         return;
      end
      ok = ident_good && machine == MACHINE_GPU && length_limit >= HEADER_BYTES;
      sec_ok = table_fits(sec_offset, sec_esize, sec_count, length_limit, sec_end);
      prg_ok = table_fits(prg_offset, prg_esize, prg_count, length_limit, prg_end);
      size = '0;
      if (ok && sec_ok && prg_ok) begin
         size = (sec_end > prg_end) ? sec_end : prg_end;
         if (size <= 64'(HEADER_BYTES)) size = '0;
      end
      r.header_valid = ok;
      r.arch_number = ok ? flags_byte : 8'd0;
      r.image_size = size[31:0];
      results_due = {results_due, r};
      byte_pos = '0;
      ident_good = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left <= 0;
      end else if (!rsp_stall_on) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if ($urandom_range(0, 99) < 60) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left <= random_gap();
      end
   end

   always @(posedge clock) begin
      header_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: result with nothing outstanding: valid %0d arch %0d size %0d",
                     $time, rsp_chan.header_valid, rsp_chan.arch_number, rsp_chan.image_size);
            error_count++;
         end else begin
            want = results_due.pop_front();
            headers_checked++;
            if (want.header_valid) valid_seen++;
            if (want.image_size != 0) sized_seen++;
            if (rsp_chan.header_valid !== want.header_valid) begin
               $display("%0t: header_valid expected %0d, got %0d", $time,
                        want.header_valid, rsp_chan.header_valid);
               error_count++;
            end
            if (rsp_chan.arch_number !== want.arch_number) begin
               $display("%0t: arch_number expected %0d, got %0d", $time,
                        want.arch_number, rsp_chan.arch_number);
               error_count++;
            end
            if (rsp_chan.image_size !== want.image_size) begin
               $display("%0t: image_size expected %0d, got %0d", $time,
                        want.image_size, rsp_chan.image_size);
               error_count++;
            end
         end
      end
   end

   // Called right after a rising edge; returns right after the edge of the transfer.
   task automatic send_byte(input logic [7:0] d, input bit fb, input logic [31:0] len);
      int gap;
      gap = req_idle_on ? random_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.first_byte <= fb;
      req_chan.available_length <= fb ? len : 32'($urandom());
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      capture_header_byte(d, fb, len);
      bytes_sent++;
   endtask

   task automatic send_header(input bit with_first, input logic [31:0] len, input int count);
      for (int i = 0; i < count; i++) send_byte(hdr[i], with_first && i == 0, len);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   function automatic void put_field(input int base, input logic [63:0] v, input int n);
      for (int k = 0; k < n; k++) hdr[base + k] = v[8*k +: 8];
   endfunction

   function automatic void set_tables(input logic [63:0] poff, input logic [15:0] pes,
                                      input logic [15:0] pec, input logic [63:0] soff,
                                      input logic [15:0] ses, input logic [15:0] sec);
      put_field(32, poff, 8);
      put_field(40, soff, 8);
      put_field(54, 64'(pes), 2);
      put_field(56, 64'(pec), 2);
      put_field(58, 64'(ses), 2);
      put_field(60, 64'(sec), 2);
   endfunction

   // Random content with a correct identification and machine word. When place is
   // set, both tables are placed inside the limit; otherwise they are left random
   // or the program table is pushed just past it.
   function automatic void make_header(input logic [31:0] lim, input bit place);
      logic [63:0] off[2];
      logic [15:0] es[2];
      logic [15:0] cnt[2];
      logic [63:0] len;
      for (int i = 0; i < 64; i++) hdr[i] = 8'($urandom_range(0, 255));
      hdr[POS_MAGIC0] = MAGIC0;
      hdr[POS_MAGIC1] = MAGIC1;
      hdr[POS_MAGIC2] = MAGIC2;
      hdr[POS_MAGIC3] = MAGIC3;
      hdr[POS_CLASS] = CLASS_64;
      put_field(18, 64'(MACHINE_GPU), 2);
      if (place) begin
         for (int t = 0; t < 2; t++) begin
            es[t] = 16'($urandom_range(0, 64));
            cnt[t] = 16'($urandom_range(0, 64));
            len = 64'(es[t]) * 64'(cnt[t]);
            if (len > 64'(lim)) begin
               cnt[t] = '0;
               len = '0;
            end
            off[t] = 64'($urandom_range(0, 32'(64'(lim) - len)));
         end
         set_tables(off[0], es[0], cnt[0], off[1], es[1], cnt[1]);
      end else if ($urandom_range(0, 1) == 1) begin
         set_tables(64'(lim) + 64'($urandom_range(1, 100)), 16'($urandom_range(0, 8)),
                    16'($urandom_range(0, 8)), 64'($urandom_range(0, 64)), 16'd1, 16'd1);
      end
   endfunction

   function automatic logic [31:0] random_limit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom();
      if (r < 20) return $urandom_range(0, 63);
      if (r < 25) return HEADER_BYTES;
      return $urandom_range(65, 8192);
   endfunction

   task automatic test_no_length_latched();
      make_header(32'd4096, 1'b1);
      send_header(1'b0, 32'd0, 64);
      wait_drained();
   endtask

   task automatic test_good_headers();
      make_header(32'd4096, 1'b0);
      hdr[POS_FLAGS] = 8'hFF;
      set_tables(64'd64, 16'd56, 16'd3, 64'd1000, 16'd64, 16'd10);
      send_header(1'b1, 32'd4096, 64);
      // Both tables end at or below 64 bytes, so the size is zero.
      make_header(HEADER_BYTES, 1'b0);
      set_tables(64'd0, 16'd64, 16'd1, 64'd10, 16'd2, 16'd3);
      send_header(1'b1, HEADER_BYTES, 64);
      make_header(32'd65, 1'b0);
      set_tables(64'd1, 16'd64, 16'd1, 64'd0, 16'd0, 16'd0);
      send_header(1'b1, 32'd65, 64);
      // A table that ends exactly at the largest length.
      make_header(32'hFFFF_FFFF, 1'b0);
      hdr[POS_FLAGS] = 8'h00;
      set_tables(64'd0, 16'd0, 16'd0, 64'hFFFF_0000, 16'hFFFF, 16'd1);
      send_header(1'b1, 32'hFFFF_FFFF, 64);
   endtask

   task automatic test_bad_identification();
      int spots[7] = '{0, 1, 2, 3, 4, 18, 19};
      foreach (spots[i]) begin
         make_header(32'd4096, 1'b1);
         hdr[spots[i]] = hdr[spots[i]] ^ 8'($urandom_range(1, 255));
         send_header(1'b1, 32'd4096, 64);
      end
      make_header(32'd63, 1'b1);
      send_header(1'b1, 32'd63, 64);
   endtask

   task automatic test_tables_not_fitting();
      make_header(32'd2000, 1'b0);
      set_tables(64'd2001, 16'd0, 16'd0, 64'd100, 16'd4, 16'd4);
      send_header(1'b1, 32'd2000, 64);
      make_header(32'd2000, 1'b0);
      set_tables(64'd100, 16'd4, 16'd4, 64'd1990, 16'd11, 16'd1);
      send_header(1'b1, 32'd2000, 64);
      make_header(32'hFFFF_FFFF, 1'b0);
      set_tables(64'h1_0000_0000, 16'd0, 16'd0, 64'd0, 16'd1, 16'd1);
      send_header(1'b1, 32'hFFFF_FFFF, 64);
      make_header(32'd4096, 1'b0);
      set_tables(64'd0, 16'hFFFF, 16'hFFFF, 64'd0, 16'd1, 16'd1);
      send_header(1'b1, 32'd4096, 64);
   endtask

   task automatic test_restart_mid_header();
      make_header(32'd3000, 1'b1);
      send_header(1'b1, 32'd3000, 20);
      make_header(32'd5000, 1'b1);
      send_header(1'b1, 32'd5000, 64);
      wait_drained();
   endtask

   task automatic test_wrap_without_first();
      make_header(32'd6000, 1'b1);
      send_header(1'b1, 32'd6000, 64);
      // The next header reuses the length latched above.
      make_header(32'd6000, 1'b1);
      send_header(1'b0, 32'd0, 64);
   endtask

   task automatic test_random_stream();
      int          r;
      int          start_bytes;
      logic [31:0] lim;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         req_idle_on = ($urandom_range(0, 4) != 0);
         rsp_stall_on = ($urandom_range(0, 4) != 0);
         lim = random_limit();
         r = $urandom_range(0, 99);
         if (r < 70) begin
            make_header(lim, $urandom_range(0, 3) != 0);
            send_header($urandom_range(0, 9) != 0, lim, 64);
         end else if (r < 82) begin
            make_header(lim, 1'b1);
            hdr[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) put_field(18, 64'($urandom_range(0, 65535)), 2);
            send_header(1'b1, lim, 64);
         end else if (r < 92) begin
            make_header(lim, 1'b1);
            send_header(1'b1, lim, $urandom_range(1, 63));
         end else begin
            repeat ($urandom_range(1, 100))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0, $urandom());
         end
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.first_byte = 1'b0;
      req_chan.available_length = '0;
      rsp_chan.ready = 1'b0;
      req_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
      byte_pos = '0;
      ident_good = 1'b1;
      machine = '0;
      flags_byte = '0;
      prg_offset = '0;
      sec_offset = '0;
      prg_esize = '0;
      prg_count = '0;
      sec_esize = '0;
      sec_count = '0;
      length_limit = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_no_length_latched();
      test_good_headers();
      test_bad_identification();
      test_tables_not_fitting();
      test_restart_mid_header();
      test_wrap_without_first();
      test_random_stream();

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d header bytes; checked %0d results, %0d valid and %0d with a size.",
               bytes_sent, headers_checked, valid_seen, sized_seen);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
